### design/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  localparam int DELAY_WIDTH = 16;
  localparam int HALF_W      = 16;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // register map
  localparam logic [APB_AW-3:0] REG_HALF_PERIOD = 1'b0;

  // engine phases
  localparam int PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ST_CHK  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RS_D1   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RS_WAIT = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RS_D2   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_ST_D    = 4'd5;
  localparam logic [PHASE_W-1:0] PH_B_D1    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_B_WAIT  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_B_D2    = 4'd8;
  localparam logic [PHASE_W-1:0] PH_SP_D1   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_SP_WAIT = 4'd10;
  localparam logic [PHASE_W-1:0] PH_SP_D2   = 4'd11;
  localparam logic [PHASE_W-1:0] PH_SP_CHK  = 4'd12;
  localparam logic [PHASE_W-1:0] PH_SP_D3   = 4'd13;

  localparam logic [3:0] ACK_SLOT = 4'd8;
  localparam logic [3:0] LAST_SLOT_DONE = 4'd9;

  typedef struct packed {
    logic       scl_in;
    logic       sda_in;
    logic       cmd_valid;
    logic       req_type;
    logic       start_req;
    logic       stop_req;
    logic [7:0] tx_byte;
    logic       tx_nack;
  } tick_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] rx_byte;
    logic       arb_lost;
  } result_t;

  // queue entry, already sorted into what the engine needs
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       cmd;
    logic       rd;
    logic       wr_start;
    logic       stop;
    logic [7:0] tx_byte;
    logic       nack;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

  // latched command: bit0 read, bit1 stop, bit2 nack
  function automatic logic slot_is_send(input logic [2:0] lcmd, input logic [3:0] bc);
    slot_is_send = lcmd[0] ? (bc == ACK_SLOT) : (bc < ACK_SLOT);
  endfunction

  function automatic logic slot_bit(input logic [2:0] lcmd, input logic [7:0] sr);
    slot_bit = lcmd[0] ? lcmd[2] : sr[7];
  endfunction

  function automatic logic slot_drive(input logic [2:0] lcmd, input logic [3:0] bc,
                                      input logic [7:0] sr);
    slot_drive = slot_is_send(lcmd, bc) ? ~slot_bit(lcmd, sr) : 1'b0;
  endfunction

endpackage
`default_nettype wire

### design/i2cm_tick_if.sv
`default_nettype none
interface i2cm_tick_if;
  import i2cm_pkg::*;
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/i2cm_result_if.sv
`default_nettype none
interface i2cm_result_if;
  import i2cm_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/i2cm_front.sv
`default_nettype none
module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  i2cm_tick_if.sink        tick,
  output queue_head_t      head,
  input  wire logic        pop
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  entry_t     entry_in;

  assign tick.ready = (count != 2'd2);
  assign push       = tick.valid && tick.ready;

  // classify the word on the way in
  always_comb begin
    entry_in.scl      = tick.data.scl_in;
    entry_in.sda      = tick.data.sda_in;
    entry_in.cmd      = tick.data.cmd_valid;
    entry_in.rd       = tick.data.req_type;
    entry_in.wr_start = ~tick.data.req_type & tick.data.start_req;
    entry_in.stop     = tick.data.stop_req;
    entry_in.tx_byte  = tick.data.tx_byte;
    entry_in.nack     = tick.data.tx_nack;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.entry = mem[rd_ptr];

endmodule
`default_nettype wire

### design/i2cm_back.sv
`default_nettype none
module i2cm_back
  import i2cm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [HALF_W-1:0] half_period,
  input  wire queue_head_t       head,
  output logic                   pop,
  i2cm_result_if.source          result
);

  logic [PHASE_W-1:0]     phase, phase_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;
  logic                   started, started_next;
  logic [2:0]             lcmd, lcmd_next;
  logic                   scl_drv, scl_drv_next;
  logic                   sda_drv, sda_drv_next;

  logic                   out_valid;
  result_t                out_data;
  result_t                res;

  logic [DELAY_WIDTH-1:0] half_m;
  logic [DELAY_WIDTH-1:0] load_val;
  logic                   dz;
  logic [3:0]             bc_inc;
  logic                   finish;
  logic                   arb;
  entry_t                 e;

  assign e   = head.entry;
  assign pop = head.valid && (!out_valid || result.ready);

  assign half_m   = DELAY_WIDTH'(half_period);
  assign load_val = (half_m == '0) ? '0 : (half_m - DELAY_WIDTH'(1));
  assign dz       = (delay_count == '0);
  assign bc_inc   = bit_count + 4'd1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = dz ? delay_count : (delay_count - DELAY_WIDTH'(1));
    started_next     = started;
    lcmd_next        = lcmd;
    scl_drv_next     = scl_drv;
    sda_drv_next     = sda_drv;
    arb              = 1'b0;
    finish           = 1'b0;

    case (phase)
      PH_IDLE: begin
        delay_count_next = delay_count;
        if (e.cmd) begin
          lcmd_next      = {e.nack, e.stop, e.rd};
          shift_reg_next = e.rd ? 8'h00 : e.tx_byte;
          bit_count_next = 4'd0;
          if (e.wr_start) begin
            sda_drv_next = 1'b0;
            if (started) begin
              delay_count_next = load_val;
              phase_next       = PH_RS_D1;
            end else begin
              phase_next = PH_ST_CHK;
            end
          end else begin
            sda_drv_next = slot_drive({e.nack, e.stop, e.rd}, 4'd0,
                                      e.rd ? 8'h00 : e.tx_byte);
            delay_count_next = load_val;
            phase_next       = PH_B_D1;
          end
        end
      end
      PH_ST_CHK: begin
        arb              = ~e.sda;
        sda_drv_next     = 1'b1;
        delay_count_next = load_val;
        phase_next       = PH_ST_D;
      end
      PH_RS_D1: begin
        if (dz) begin
          scl_drv_next = 1'b0;
          phase_next   = PH_RS_WAIT;
        end
      end
      PH_RS_WAIT: begin
        delay_count_next = delay_count;
        if (e.scl) begin
          delay_count_next = load_val;
          phase_next       = PH_RS_D2;
        end
      end
      PH_RS_D2: begin
        if (dz) begin
          arb              = ~e.sda;
          sda_drv_next     = 1'b1;
          delay_count_next = load_val;
          phase_next       = PH_ST_D;
        end
      end
      PH_ST_D: begin
        if (dz) begin
          scl_drv_next     = 1'b1;
          started_next     = 1'b1;
          sda_drv_next     = slot_drive(lcmd, bit_count, shift_reg);
          delay_count_next = load_val;
          phase_next       = PH_B_D1;
        end
      end
      PH_B_D1: begin
        if (dz) begin
          scl_drv_next = 1'b0;
          phase_next   = PH_B_WAIT;
        end
      end
      PH_B_WAIT: begin
        delay_count_next = delay_count;
        if (e.scl) begin
          if (slot_is_send(lcmd, bit_count)) begin
            arb = slot_bit(lcmd, shift_reg) & ~e.sda;
            if (!lcmd[0]) begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
            end
          end else begin
            shift_reg_next = {shift_reg[6:0], e.sda};
          end
          delay_count_next = load_val;
          phase_next       = PH_B_D2;
        end
      end
      PH_B_D2: begin
        if (dz) begin
          scl_drv_next   = 1'b1;
          bit_count_next = bc_inc;
          if (bc_inc >= LAST_SLOT_DONE) begin
            if (lcmd[1]) begin
              sda_drv_next     = 1'b1;
              delay_count_next = load_val;
              phase_next       = PH_SP_D1;
            end else begin
              finish = 1'b1;
            end
          end else begin
            sda_drv_next     = slot_drive(lcmd, bc_inc, shift_reg);
            delay_count_next = load_val;
            phase_next       = PH_B_D1;
          end
        end
      end
      PH_SP_D1: begin
        if (dz) begin
          scl_drv_next = 1'b0;
          phase_next   = PH_SP_WAIT;
        end
      end
      PH_SP_WAIT: begin
        delay_count_next = delay_count;
        if (e.scl) begin
          delay_count_next = load_val;
          phase_next       = PH_SP_D2;
        end
      end
      PH_SP_D2: begin
        if (dz) begin
          sda_drv_next = 1'b0;
          phase_next   = PH_SP_CHK;
        end
      end
      PH_SP_CHK: begin
        arb              = ~e.sda;
        delay_count_next = load_val;
        phase_next       = PH_SP_D3;
      end
      PH_SP_D3: begin
        if (dz) begin
          started_next = 1'b0;
          finish       = 1'b1;
        end
      end
      default: begin
        delay_count_next = delay_count;
        phase_next       = PH_IDLE;
      end
    endcase

    if (finish) begin
      phase_next = PH_IDLE;
    end

    res.scl_low   = scl_drv_next;
    res.sda_low   = sda_drv_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = finish;
    res.nack_seen = finish & ~lcmd[0] & shift_reg[0];
    res.rx_byte   = (finish & lcmd[0]) ? shift_reg : 8'h00;
    res.arb_lost  = arb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'h00;
      delay_count <= '0;
      started     <= 1'b0;
      lcmd        <= 3'd0;
      scl_drv     <= 1'b0;
      sda_drv     <= 1'b0;
    end else if (pop) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      started     <= started_next;
      lcmd        <= lcmd_next;
      scl_drv     <= scl_drv_next;
      sda_drv     <= sda_drv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule
`default_nettype wire

### design/i2c_master_byte_engine.sv
`default_nettype none
// i2c master byte engine: every word on the tick channel is one clock tick of
// the bus, carrying the sampled scl/sda levels and an optional byte command
// (write with optional start or repeated start, or read with the ack/nack bit
// to send, either with optional stop). every accepted tick yields exactly one
// result word with the line drives, busy, done, the sampled ack after a write,
// the received byte after a read and a one-tick arbitration-lost flag. the
// engine waits without limit while a slave stretches scl, and a command that
// arrives while busy is dropped. the front end takes tick words into a
// two-entry queue; the back end pops one entry per cycle unless the queue is
// empty or the result side stalls, advances the phase machine by one tick and
// registers the result word. sustained rate is one word per clock in both
// directions unless the result side stalls; a result passes through the
// queue entry and then the single output register of the back end. a stall on
// the result side fills the queue and then drops tick ready. half_period_ticks
// (byte address 0, reset 250) sets every delay between line changes; zero
// counts as one tick. it may only be written while no tick is in flight.
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  i2cm_tick_if.sink              tick,
  i2cm_result_if.source          result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [HALF_W-1:0] half_period;
  logic              reg_hit;
  logic              pop;
  queue_head_t       head;

  // config register, word aligned
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_HALF_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_W'(250);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      half_period <= pwdata[HALF_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(APB_DW-HALF_W){1'b0}}, half_period} : '0;

  // front end: tick queue
  i2cm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .head (head),
    .pop  (pop)
  );

  // back end: phase machine and result register
  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .half_period (half_period),
    .head        (head),
    .pop         (pop),
    .result      (result)
  );

endmodule
`default_nettype wire
